// ===== hw/rtl/cmfuv_pkg.sv =====
`timescale 1ns / 1ps

package cmfuv_pkg;

	// dominant axis code as it leaves the block on major_axis
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

endpackage

// ===== hw/rtl/cmfuv_dir_if.sv =====
`timescale 1ns / 1ps

interface cmfuv_dir_if #(
	parameter int DIR_BITS = 16
) ();
	logic                       valid;
	logic                       ready;
	logic signed [DIR_BITS-1:0] dir_x;
	logic signed [DIR_BITS-1:0] dir_y;
	logic signed [DIR_BITS-1:0] dir_z;

	modport source (
		output valid,
		output dir_x,
		output dir_y,
		output dir_z,
		input  ready
	);

	modport sink (
		input  valid,
		input  dir_x,
		input  dir_y,
		input  dir_z,
		output ready
	);
endinterface

// ===== hw/rtl/cmfuv_face_if.sv =====
`timescale 1ns / 1ps

interface cmfuv_face_if #(
	parameter int UV_BITS = 16
) ();
	logic               valid;
	logic               ready;
	logic [1:0]         major_axis;
	logic               major_positive;
	logic [UV_BITS-1:0] u_coord;
	logic [UV_BITS-1:0] v_coord;
	logic               zero_vector;

	modport source (
		output valid,
		output major_axis,
		output major_positive,
		output u_coord,
		output v_coord,
		output zero_vector,
		input  ready
	);

	modport sink (
		input  valid,
		input  major_axis,
		input  major_positive,
		input  u_coord,
		input  v_coord,
		input  zero_vector,
		output ready
	);
endinterface

// ===== hw/rtl/cube_map_face_uv.sv =====
// throughput: one beat per cycle while face.ready is high; the two restoring dividers retire one quotient bit per stage
// pipeline is UV_BITS+5 stages: magnitude, axis select, numerator, UV_BITS+1 divide, output
// stalls back up stage by stage; empty stages keep filling while a result waits
// reset (arst_n low, asynchronous) clears the stage valid bits only; no clearing pass
`timescale 1ns / 1ps

module cube_map_face_uv #(
	parameter int DIR_BITS = 16,
	parameter int UV_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	cmfuv_dir_if.sink           dir,
	cmfuv_face_if.source        face
);

	localparam int DSTG = UV_BITS + 1;              // quotient bits, one per divide stage
	localparam int NW   = DIR_BITS + UV_BITS + 2;   // dividend width
	localparam int RW   = DIR_BITS + 1;             // divisor and remainder width

	// stage 1: magnitudes
	logic                       valid_s1;
	logic signed [DIR_BITS-1:0] cx_s1, cy_s1, cz_s1;
	logic        [DIR_BITS-1:0] ax_s1, ay_s1, az_s1;
	logic                       adv_s1;

	// stage 2: axis select
	logic                       valid_s2;
	cmfuv_pkg::axis_t           axis_s2;
	logic                       pos_s2;
	logic                       zero_s2;
	logic                       plus_s2;
	logic        [DIR_BITS-1:0] m_s2;
	logic signed [DIR_BITS-1:0] mu_s2, mv_s2;
	logic                       adv_s2;

	// divider chain; entry 0 holds the numerator stage
	logic                   dvalid_sd [DSTG+1];
	cmfuv_pkg::axis_t       axis_sd   [DSTG+1];
	logic                   pos_sd    [DSTG+1];
	logic                   zero_sd   [DSTG+1];
	logic [RW-1:0]          d_sd      [DSTG+1];
	logic [RW-1:0]          rem_u_sd  [DSTG+1];
	logic [RW-1:0]          rem_v_sd  [DSTG+1];
	logic [UV_BITS:0]       nlo_u_sd  [DSTG+1];
	logic [UV_BITS:0]       nlo_v_sd  [DSTG+1];
	logic [UV_BITS:0]       q_u_sd    [DSTG+1];
	logic [UV_BITS:0]       q_v_sd    [DSTG+1];
	logic                   adv_sd    [DSTG+2];

	// output stage
	logic                   valid_so;
	cmfuv_pkg::axis_t       axis_so;
	logic                   pos_so;
	logic                   zero_so;
	logic [UV_BITS-1:0]     u_so, v_so;
	logic                   adv_so;

	// stall chain: a stage moves when it is empty or its successor moves
	assign adv_so              = !valid_so || face.ready;
	assign adv_sd[DSTG+1]      = adv_so;
	assign adv_s2              = !valid_s2 || adv_sd[0];
	assign adv_s1              = !valid_s1 || adv_s2;
	assign dir.ready           = adv_s1;

	// ---------------- stage 1 ----------------
	logic [DIR_BITS-1:0] abs_x, abs_y, abs_z;

	always_comb begin
		abs_x = dir.dir_x[DIR_BITS-1] ? DIR_BITS'(-dir.dir_x) : DIR_BITS'(dir.dir_x);
		abs_y = dir.dir_y[DIR_BITS-1] ? DIR_BITS'(-dir.dir_y) : DIR_BITS'(dir.dir_y);
		abs_z = dir.dir_z[DIR_BITS-1] ? DIR_BITS'(-dir.dir_z) : DIR_BITS'(dir.dir_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= dir.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cx_s1 <= dir.dir_x;
			cy_s1 <= dir.dir_y;
			cz_s1 <= dir.dir_z;
			ax_s1 <= abs_x;
			ay_s1 <= abs_y;
			az_s1 <= abs_z;
		end
	end

	// ---------------- stage 2 ----------------
	cmfuv_pkg::axis_t           axis_c;
	logic        [DIR_BITS-1:0] m_c;
	logic signed [DIR_BITS-1:0] csel_c, mu_c, mv_c;
	logic                       zero_c, pos_c;

	always_comb begin
		// strict compares: ties go to x over y, and to x or y over z
		if (az_s1 > ax_s1 && az_s1 > ay_s1) begin
			axis_c = cmfuv_pkg::AXIS_Z;
		end else if (ay_s1 > ax_s1) begin
			axis_c = cmfuv_pkg::AXIS_Y;
		end else begin
			axis_c = cmfuv_pkg::AXIS_X;
		end
		case (axis_c)
			cmfuv_pkg::AXIS_Y: begin
				m_c    = ay_s1;
				csel_c = cy_s1;
				mu_c   = cx_s1;
				mv_c   = cz_s1;
			end
			cmfuv_pkg::AXIS_Z: begin
				m_c    = az_s1;
				csel_c = cz_s1;
				mu_c   = cx_s1;
				mv_c   = cy_s1;
			end
			default: begin
				m_c    = ax_s1;
				csel_c = cx_s1;
				mu_c   = cz_s1;
				mv_c   = cy_s1;
			end
		endcase
		zero_c = (ax_s1 == '0) && (ay_s1 == '0) && (az_s1 == '0);
		pos_c  = !csel_c[DIR_BITS-1] && (csel_c != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			axis_s2 <= zero_c ? cmfuv_pkg::AXIS_X : axis_c;
			pos_s2  <= pos_c;
			zero_s2 <= zero_c;
			plus_s2 <= (pos_c == (axis_c != cmfuv_pkg::AXIS_Z));
			m_s2    <= m_c;
			mu_s2   <= mu_c;
			mv_s2   <= mv_c;
		end
	end

	// ---------------- numerator stage ----------------
	// n = M +/- minor lies in [0, 2M]; dividend is n * 2^UV_BITS + M over 2M
	logic signed [DIR_BITS+1:0] mag_w, mu_w, mv_w, nu_w, nv_w;
	logic        [NW-1:0]       num_u, num_v;

	always_comb begin
		mag_w = $signed({2'b00, m_s2});
		mu_w  = {{2{mu_s2[DIR_BITS-1]}}, mu_s2};
		mv_w  = {{2{mv_s2[DIR_BITS-1]}}, mv_s2};
		nu_w  = plus_s2 ? (mag_w + mu_w) : (mag_w - mu_w);
		nv_w  = mag_w - mv_w;
		num_u = {1'b0, nu_w[DIR_BITS:0], {UV_BITS{1'b0}}} + {{(UV_BITS+2){1'b0}}, m_s2};
		num_v = {1'b0, nv_w[DIR_BITS:0], {UV_BITS{1'b0}}} + {{(UV_BITS+2){1'b0}}, m_s2};
	end

	assign adv_sd[0] = !dvalid_sd[0] || adv_sd[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_sd[0] <= 1'b0;
		end else if (adv_sd[0]) begin
			dvalid_sd[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_sd[0]) begin
			axis_sd[0]  <= axis_s2;
			pos_sd[0]   <= pos_s2;
			zero_sd[0]  <= zero_s2;
			d_sd[0]     <= {m_s2, 1'b0};
			// quotient fits in UV_BITS+1 bits, so the high part starts below 2M
			rem_u_sd[0] <= num_u[NW-1:UV_BITS+1];
			rem_v_sd[0] <= num_v[NW-1:UV_BITS+1];
			nlo_u_sd[0] <= num_u[UV_BITS:0];
			nlo_v_sd[0] <= num_v[UV_BITS:0];
			q_u_sd[0]   <= '0;
			q_v_sd[0]   <= '0;
		end
	end

	// ---------------- restoring divide, one quotient bit per stage ----------------
	for (genvar j = 1; j <= DSTG; j++) begin : g_div
		localparam int B = UV_BITS - (j - 1);

		logic [RW:0] tu, tv;
		logic        geu, gev;

		assign tu  = {rem_u_sd[j-1], nlo_u_sd[j-1][B]};
		assign tv  = {rem_v_sd[j-1], nlo_v_sd[j-1][B]};
		assign geu = tu >= {1'b0, d_sd[j-1]};
		assign gev = tv >= {1'b0, d_sd[j-1]};

		assign adv_sd[j] = !dvalid_sd[j] || adv_sd[j+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvalid_sd[j] <= 1'b0;
			end else if (adv_sd[j]) begin
				dvalid_sd[j] <= dvalid_sd[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv_sd[j]) begin
				axis_sd[j]  <= axis_sd[j-1];
				pos_sd[j]   <= pos_sd[j-1];
				zero_sd[j]  <= zero_sd[j-1];
				d_sd[j]     <= d_sd[j-1];
				nlo_u_sd[j] <= nlo_u_sd[j-1];
				nlo_v_sd[j] <= nlo_v_sd[j-1];
				rem_u_sd[j] <= geu ? RW'(tu - {1'b0, d_sd[j-1]}) : tu[RW-1:0];
				rem_v_sd[j] <= gev ? RW'(tv - {1'b0, d_sd[j-1]}) : tv[RW-1:0];
				q_u_sd[j]   <= {q_u_sd[j-1][UV_BITS-1:0], geu};
				q_v_sd[j]   <= {q_v_sd[j-1][UV_BITS-1:0], gev};
			end
		end
	end

	// ---------------- output stage ----------------
	localparam logic [UV_BITS-1:0] CENTRE = {1'b1, {(UV_BITS-1){1'b0}}};

	logic [UV_BITS-1:0] u_sat, v_sat;

	always_comb begin
		// only an exact 1.0 reaches the top quotient bit
		u_sat = q_u_sd[DSTG][UV_BITS] ? {UV_BITS{1'b1}} : q_u_sd[DSTG][UV_BITS-1:0];
		v_sat = q_v_sd[DSTG][UV_BITS] ? {UV_BITS{1'b1}} : q_v_sd[DSTG][UV_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else if (adv_so) begin
			valid_so <= dvalid_sd[DSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_so) begin
			axis_so <= axis_sd[DSTG];
			pos_so  <= pos_sd[DSTG];
			zero_so <= zero_sd[DSTG];
			u_so    <= zero_sd[DSTG] ? CENTRE : u_sat;
			v_so    <= zero_sd[DSTG] ? CENTRE : v_sat;
		end
	end

	assign face.valid          = valid_so;
	assign face.major_axis     = axis_so;
	assign face.major_positive = pos_so;
	assign face.u_coord        = u_so;
	assign face.v_coord        = v_so;
	assign face.zero_vector    = zero_so;

	// ---------------- assertions ----------------
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		dir.valid && dir.ready |=> valid_s1)
		else $error("accepted beat did not reach stage 1");

	a_num_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		dvalid_sd[0] && !adv_sd[0] |=> dvalid_sd[0] && $stable(rem_u_sd[0]) &&
			$stable(rem_v_sd[0]))
		else $error("stalled numerator stage changed");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dvalid_sd[DSTG] && !zero_sd[DSTG] |->
			rem_u_sd[DSTG] < d_sd[DSTG] && rem_v_sd[DSTG] < d_sd[DSTG])
		else $error("divider remainder not below divisor");

	a_zero_centre: assert property (@(posedge clk) disable iff (!arst_n)
		face.valid && face.zero_vector |->
			face.u_coord == CENTRE && face.v_coord == CENTRE && !face.major_positive)
		else $error("zero vector beat not at face centre");

	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && zero_s2 |-> axis_s2 == cmfuv_pkg::AXIS_X && !pos_s2)
		else $error("zero vector selected a non-x axis");

endmodule
